@@ src/spin_density_matrix_engine_unit_defines.svh @@
// Assertion macros for the density matrix engine RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef SPIN_DENSITY_MATRIX_ENGINE_UNIT_DEFINES_SVH
`define SPIN_DENSITY_MATRIX_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SDME_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SDME_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/sdme_pkg.sv @@
// Shared types and constants for the density matrix engine.
// No dependencies; used by the interfaces and every module but sdme_ram.
package sdme_pkg;

  localparam int OCC_W      = 5;
  localparam int IDX_IN_W   = 4;
  localparam int SPIN_W     = 2;
  localparam int COEFF_IN_W = 16;
  localparam int DENS_W     = 40;
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;
  localparam int REG_IDX_W  = 2;

  localparam logic              OP_WRITE = 1'b0;
  localparam logic              OP_READ  = 1'b1;

  localparam logic [SPIN_W-1:0] SPIN_ALPHA = 2'd0;
  localparam logic [SPIN_W-1:0] SPIN_BETA  = 2'd1;

  localparam logic [REG_IDX_W-1:0] REG_ALPHA_OCC = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_BETA_OCC  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_COLUMNS   = 2'd2;

  localparam logic [OCC_W-1:0] COLUMNS_RESET = 5'd16;

  localparam logic signed [DENS_W-1:0] DENS_MAX = 40'sh7F_FFFF_FFFF;
  localparam logic signed [DENS_W-1:0] DENS_MIN = 40'sh80_0000_0000;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN
  } seq_state_e;

  typedef struct packed {
    logic [OCC_W-1:0] alpha_occ;
    logic [OCC_W-1:0] beta_occ;
    logic [OCC_W-1:0] columns;
  } cfg_t;

  typedef struct packed {
    logic clear;
    logic valid;
  } mac_ctrl_t;

endpackage

@@ src/sdme_if.sv @@
// Valid/ready channel interfaces for request and result words.
// Depends on sdme_pkg for field widths.
interface sdme_in_if;
  import sdme_pkg::*;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [SPIN_W-1:0]            spin_select;
  logic [IDX_IN_W-1:0]          row_index;
  logic [IDX_IN_W-1:0]          col_index;
  logic signed [COEFF_IN_W-1:0] coeff_value;

  modport source (output valid, opcode, spin_select, row_index, col_index, coeff_value,
                  input ready);
  modport sink (input valid, opcode, spin_select, row_index, col_index, coeff_value,
                output ready);
endinterface

interface sdme_out_if;
  import sdme_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DENS_W-1:0] density_value;
  logic                     occupation_error;

  modport source (output valid, density_value, occupation_error, input ready);
  modport sink (input valid, density_value, occupation_error, output ready);
endinterface

@@ src/sdme_ram.sv @@
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module sdme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

@@ src/sdme_cfg.sv @@
// APB register block for occupation counts and columns in use.
// Depends on sdme_pkg.
module sdme_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sdme_pkg::PADDR_W-1:0]   paddr,
  input  logic [sdme_pkg::PDATA_W-1:0]   pwdata,
  output logic [sdme_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  output sdme_pkg::cfg_t                 cfg_o
);
  import sdme_pkg::*;

  cfg_t                 cfg_q, cfg_d;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[REG_IDX_W+1:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_ALPHA_OCC: cfg_d.alpha_occ = pwdata[OCC_W-1:0];
        REG_BETA_OCC:  cfg_d.beta_occ  = pwdata[OCC_W-1:0];
        REG_COLUMNS:   cfg_d.columns   = pwdata[OCC_W-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ALPHA_OCC: prdata = PDATA_W'(cfg_q.alpha_occ);
      REG_BETA_OCC:  prdata = PDATA_W'(cfg_q.beta_occ);
      REG_COLUMNS:   prdata = PDATA_W'(cfg_q.columns);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alpha_occ <= '0;
      cfg_q.beta_occ  <= '0;
      cfg_q.columns   <= COLUMNS_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/sdme_mac.sv @@
// Shared multiply-accumulate unit: registered product, saturating add.
// Depends on sdme_pkg for the accumulator width and control struct.
module sdme_mac #(
  parameter int CW = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  sdme_pkg::mac_ctrl_t                ctrl_i,
  input  logic signed [CW-1:0]               coeff_a_i,
  input  logic signed [CW-1:0]               coeff_b_i,
  output logic signed [sdme_pkg::DENS_W-1:0] acc_o,
  output logic                               busy_o
);
  import sdme_pkg::*;

  localparam int PW = 2 * CW;
  localparam int SW = ((PW > DENS_W) ? PW : DENS_W) + 1;
  localparam logic signed [SW-1:0] S_MAX = SW'(DENS_MAX);
  localparam logic signed [SW-1:0] S_MIN = SW'(DENS_MIN);

  logic signed [PW-1:0]     prod_q;
  logic                     prod_v_q;
  logic signed [DENS_W-1:0] acc_q, acc_d;
  logic signed [SW-1:0]     sum;

  // Stage one: multiply.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
    end else begin
      prod_v_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.valid) begin
      prod_q <= coeff_a_i * coeff_b_i;
    end
  end

  // Stage two: add and clamp to the output range after every term.
  assign sum = SW'(acc_q) + SW'(prod_q);

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (prod_v_q) begin
      if (sum > S_MAX) begin
        acc_d = DENS_MAX;
      end else if (sum < S_MIN) begin
        acc_d = DENS_MIN;
      end else begin
        acc_d = DENS_W'(sum);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o  = acc_q;
  assign busy_o = prod_v_q;

endmodule

@@ src/spin_density_matrix_engine_unit.sv @@
// Top level of the unrestricted density matrix engine: sequencer, stores, MAC.
// Depends on sdme_pkg, sdme_if, sdme_ram, sdme_cfg, sdme_mac and the defines header.
//
//   channel  | dir | handshake            | word
//   ---------+-----+----------------------+---------------------------------------------
//   in_i     | in  | valid/ready          | opcode, spin_select, row_index, col_index,
//            |     |                      | coeff_value
//   out_o    | out | valid/ready          | density_value, occupation_error
//   apb      | in  | psel/penable, pready | paddr, pwdata, prdata (3 registers)
//
// A coefficient write yields no result word.
// A read walks the occupied alpha and beta columns, or none on an occupation error;
// the single multiply-accumulate unit retires one product per cycle.
// Reset clears the registers and the sequencer; the coefficient stores are not cleared.
// A result waits in the output register; the next word is taken meanwhile, and a
// read finishing against a stalled output holds until the register frees up.
`include "spin_density_matrix_engine_unit_defines.svh"

module spin_density_matrix_engine_unit #(
  parameter int MAX_BASIS   = 16,
  parameter int COEFF_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sdme_pkg::PADDR_W-1:0] paddr,
  input  logic [sdme_pkg::PDATA_W-1:0] pwdata,
  output logic [sdme_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  sdme_in_if.sink                      in_i,
  sdme_out_if.source                   out_o
);
  import sdme_pkg::*;

  localparam int CW    = COEFF_WIDTH;
  localparam int IW    = $clog2(MAX_BASIS);
  localparam int AW    = 2 * IW;
  localparam int DEPTH = MAX_BASIS << IW;
  // Index staging width: holds row/col inputs and the column counter.
  localparam int XW    = (IW > OCC_W) ? IW : OCC_W;
  // Compare width: holds MAX_BASIS itself and any register value.
  localparam int BW    = $clog2(MAX_BASIS + 1);
  localparam int EW    = (BW > OCC_W) ? BW : OCC_W;
  localparam logic [EW-1:0] MB = EW'(MAX_BASIS);

  cfg_t       cfg;
  mac_ctrl_t  mac_ctrl;
  seq_state_e state_q, state_d;

  logic                     in_fire, wr_accept, rd_accept;
  logic                     in_row_ok, in_col_ok;
  logic [XW-1:0]            in_row_x, in_col_x;
  logic [AW-1:0]            waddr;
  logic signed [CW-1:0]     coeff_cv;
  logic                     we_alpha, we_beta;

  logic [EW-1:0]            eff_cols;
  logic                     rd_use_a, rd_use_b, rd_err;

  logic [OCC_W-1:0]         k_q, k_d;
  logic [OCC_W-1:0]         cur_occ;
  logic                     beta_phase_q, beta_phase_d;
  logic                     use_b_q, use_b_d;
  logic                     err_q, err_d;
  logic [IW-1:0]            row_q, col_q;
  logic                     row_bad_q, col_bad_q;
  logic                     issue, rd_v_q, rd_beta_q;
  logic [XW-1:0]            k_x;
  logic [AW-1:0]            raddr_a, raddr_b;
  logic [CW-1:0]            alpha_rd_a, alpha_rd_b, beta_rd_a, beta_rd_b;
  logic signed [CW-1:0]     coeff_a, coeff_b;
  logic signed [DENS_W-1:0] acc;
  logic                     mac_busy, pipe_busy;
  logic                     mac_clr, out_load;

  logic                     out_valid_q;
  logic signed [DENS_W-1:0] out_val_q;
  logic                     out_err_q;

  sdme_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // ---------------------------------------------------------------------------
  // Input side: take a word only while the sequencer is idle.
  // ---------------------------------------------------------------------------
  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid & in_i.ready;
  assign wr_accept  = in_fire & (in_i.opcode == OP_WRITE);
  assign rd_accept  = in_fire & (in_i.opcode == OP_READ);

  assign in_row_x  = XW'(in_i.row_index);
  assign in_col_x  = XW'(in_i.col_index);
  assign in_row_ok = EW'(in_i.row_index) < MB;
  assign in_col_ok = EW'(in_i.col_index) < MB;
  assign waddr     = {in_row_x[IW-1:0], in_col_x[IW-1:0]};

  // Bring the Q4.12 input into the stored coefficient width.
  generate
    if (CW < COEFF_IN_W) begin : g_coeff_sat
      localparam logic signed [COEFF_IN_W-1:0] C_HI = COEFF_IN_W'(2 ** (CW - 1) - 1);
      localparam logic signed [COEFF_IN_W-1:0] C_LO = COEFF_IN_W'(-(2 ** (CW - 1)));
      always_comb begin
        if (in_i.coeff_value > C_HI) begin
          coeff_cv = CW'(C_HI);
        end else if (in_i.coeff_value < C_LO) begin
          coeff_cv = CW'(C_LO);
        end else begin
          coeff_cv = CW'(in_i.coeff_value);
        end
      end
    end else begin : g_coeff_ext
      always_comb begin
        coeff_cv = CW'(in_i.coeff_value);
      end
    end
  endgenerate

  // Spin codes other than alpha and beta drop the write.
  assign we_alpha = wr_accept & in_row_ok & in_col_ok & (in_i.spin_select == SPIN_ALPHA);
  assign we_beta  = wr_accept & in_row_ok & in_col_ok & (in_i.spin_select == SPIN_BETA);

  // ---------------------------------------------------------------------------
  // Occupation check against the effective column count.
  // ---------------------------------------------------------------------------
  assign eff_cols = (EW'(cfg.columns) < MB) ? EW'(cfg.columns) : MB;
  assign rd_use_a = (in_i.spin_select != SPIN_BETA);
  assign rd_use_b = (in_i.spin_select != SPIN_ALPHA);
  assign rd_err   = (rd_use_a & (EW'(cfg.alpha_occ) > eff_cols)) |
                    (rd_use_b & (EW'(cfg.beta_occ) > eff_cols));

  // ---------------------------------------------------------------------------
  // Sequencer: walk the occupied columns, alpha first, then beta.
  // ---------------------------------------------------------------------------
  assign cur_occ   = beta_phase_q ? cfg.beta_occ : cfg.alpha_occ;
  assign pipe_busy = rd_v_q | mac_busy;

  always_comb begin
    state_d      = state_q;
    k_d          = k_q;
    beta_phase_d = beta_phase_q;
    use_b_d      = use_b_q;
    err_d        = err_q;
    issue        = 1'b0;
    mac_clr      = 1'b0;
    out_load     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (rd_accept) begin
          mac_clr      = 1'b1;
          err_d        = rd_err;
          k_d          = '0;
          beta_phase_d = !rd_use_a;
          use_b_d      = rd_use_b;
          state_d      = rd_err ? S_DRAIN : S_RUN;
        end
      end
      S_RUN: begin
        if (k_q < cur_occ) begin
          issue = 1'b1;
          k_d   = k_q + OCC_W'(1);
        end else if (!beta_phase_q && use_b_q) begin
          beta_phase_d = 1'b1;
          k_d          = '0;
        end else begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // Hold until the MAC has retired every product and the output frees up.
        if (!pipe_busy && (!out_valid_q || out_o.ready)) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      k_q          <= '0;
      beta_phase_q <= 1'b0;
      use_b_q      <= 1'b0;
      err_q        <= 1'b0;
      rd_v_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      k_q          <= k_d;
      beta_phase_q <= beta_phase_d;
      use_b_q      <= use_b_d;
      err_q        <= err_d;
      rd_v_q       <= issue;
    end
  end

  // Latch the requested element; out-of-range rows or columns read as zero.
  always_ff @(posedge clk_i) begin
    if (rd_accept) begin
      row_q     <= in_row_x[IW-1:0];
      col_q     <= in_col_x[IW-1:0];
      row_bad_q <= !in_row_ok;
      col_bad_q <= !in_col_ok;
    end
    if (issue) begin
      rd_beta_q <= beta_phase_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Coefficient stores, read at (row, k) and (col, k) in the same cycle.
  // ---------------------------------------------------------------------------
  assign k_x     = XW'(k_q);
  assign raddr_a = {row_q, k_x[IW-1:0]};
  assign raddr_b = {col_q, k_x[IW-1:0]};

  sdme_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_alpha_store (
    .clk_i     (clk_i),
    .we_i      (we_alpha),
    .waddr_i   (waddr),
    .wdata_i   (coeff_cv),
    .re_i      (issue),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (alpha_rd_a),
    .rdata_b_o (alpha_rd_b)
  );

  sdme_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_beta_store (
    .clk_i     (clk_i),
    .we_i      (we_beta),
    .waddr_i   (waddr),
    .wdata_i   (coeff_cv),
    .re_i      (issue),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (beta_rd_a),
    .rdata_b_o (beta_rd_b)
  );

  assign coeff_a = row_bad_q ? '0 : $signed(rd_beta_q ? beta_rd_a : alpha_rd_a);
  assign coeff_b = col_bad_q ? '0 : $signed(rd_beta_q ? beta_rd_b : alpha_rd_b);

  assign mac_ctrl.clear = mac_clr;
  assign mac_ctrl.valid = rd_v_q;

  sdme_mac #(.CW(CW)) u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (mac_ctrl),
    .coeff_a_i (coeff_a),
    .coeff_b_i (coeff_b),
    .acc_o     (acc),
    .busy_o    (mac_busy)
  );

  // ---------------------------------------------------------------------------
  // Output register: advance on load, hold while the sink stalls.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_load | (out_valid_q & !out_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_val_q <= acc;
      out_err_q <= err_q;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.density_value    = out_val_q;
  assign out_o.occupation_error = out_err_q;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `SDME_ASSERT_NOW(a_err_zero, clk_i, rst_ni, out_valid_q && out_err_q, out_val_q == '0,
    "occupation error result carries a nonzero density")
  `SDME_ASSERT_NOW(a_k_bound, clk_i, rst_ni, state_q == S_RUN, k_q <= cur_occ,
    "column counter ran past the occupation count")
  `SDME_ASSERT_NOW(a_wr_idle, clk_i, rst_ni, we_alpha || we_beta, state_q == S_IDLE,
    "coefficient write outside idle")
  `SDME_ASSERT_NOW(a_idle_empty, clk_i, rst_ni, state_q == S_IDLE, !pipe_busy,
    "MAC pipeline busy while idle")
  `SDME_ASSERT_NEXT(a_rd_leaves_idle, clk_i, rst_ni, rd_accept, state_q != S_IDLE,
    "accepted read did not start the sequencer")

endmodule

@@ tb/sv/tb_spin_density_matrix_engine_unit.sv @@
// Self-checking testbench for spin_density_matrix_engine_unit: loads coefficients, reads
// alpha/beta/total density words and checks each one against a local predictor.
// Depends on sdme_pkg, sdme_if and the engine RTL.
`timescale 1ns / 1ps

module tb_spin_density_matrix_engine_unit;
  import sdme_pkg::*;

  localparam int BASIS         = 16;
  localparam int SETTLE_CYCLES = 48;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int REPORT_LIMIT  = 10;
  localparam int PHASE_WORDS   = 62;

  // Spin codes the package leaves unnamed.
  localparam logic [SPIN_W-1:0] SPIN_TOTAL       = 2'd2;
  localparam logic [SPIN_W-1:0] SPIN_TOTAL_ALIAS = 2'd3;

  typedef struct packed {
    logic                         opcode;
    logic [SPIN_W-1:0]            spin;
    logic [IDX_IN_W-1:0]          row;
    logic [IDX_IN_W-1:0]          col;
    logic signed [COEFF_IN_W-1:0] coeff;
  } request_word_t;

  typedef struct packed {
    logic signed [DENS_W-1:0] density;
    logic                     occ_error;
  } density_word_t;

  // Receiver stall behaviors; the receiver picks one at random for each stretch.
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_PATTERN,
    RX_SPARSE
  } rx_mode_e;

  logic                 clk_i  = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  sdme_in_if  in_bus ();
  sdme_out_if out_bus ();

  spin_density_matrix_engine_unit #(
    .MAX_BASIS  (BASIS),
    .COEFF_WIDTH(COEFF_IN_W)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of both coefficient stores and of the
  // three registers, updated as words and register writes are accepted.
  // ---------------------------------------------------------------------------
  logic signed [COEFF_IN_W-1:0] alpha_c [BASIS][BASIS];
  logic signed [COEFF_IN_W-1:0] beta_c  [BASIS][BASIS];
  logic [OCC_W-1:0]             cfg_alpha_occ = '0;
  logic [OCC_W-1:0]             cfg_beta_occ  = '0;
  logic [OCC_W-1:0]             cfg_columns   = COLUMNS_RESET;

  density_word_t density_expect_q [$];
  request_word_t pending_words [$];

  // Entries the stimulus has already scheduled a write for; a read is only
  // issued once every coefficient it touches is covered here.
  bit alpha_loaded [BASIS][BASIS];
  bit beta_loaded  [BASIS][BASIS];

  int words_queued   = 0;
  int words_accepted = 0;
  int reads_seen     = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;

  // Add occ products of row and col pairs from one store, clamping the running
  // sum to 40 bits after every addition as the hardware accumulator does.
  function automatic longint fold_products(longint acc, bit from_beta, int occ,
                                           logic [IDX_IN_W-1:0] row,
                                           logic [IDX_IN_W-1:0] col);
    logic signed [COEFF_IN_W-1:0] a;
    logic signed [COEFF_IN_W-1:0] b;
    for (int k = 0; k < occ; k++) begin
      a   = from_beta ? beta_c[row][k] : alpha_c[row][k];
      b   = from_beta ? beta_c[col][k] : alpha_c[col][k];
      acc = acc + longint'(a) * longint'(b);
      if (acc > longint'(DENS_MAX)) acc = longint'(DENS_MAX);
      if (acc < longint'(DENS_MIN)) acc = longint'(DENS_MIN);
    end
    return acc;
  endfunction

  function automatic density_word_t density_element(logic [SPIN_W-1:0] spin,
                                                    logic [IDX_IN_W-1:0] row,
                                                    logic [IDX_IN_W-1:0] col);
    density_word_t w;
    logic [OCC_W-1:0] eff_cols;
    bit use_alpha;
    bit use_beta;
    longint acc;
    // Columns above the basis size clamp to the basis; spin 3 acts as total.
    eff_cols  = (cfg_columns > BASIS) ? OCC_W'(BASIS) : cfg_columns;
    use_alpha = (spin != SPIN_BETA);
    use_beta  = (spin != SPIN_ALPHA);
    w.occ_error = (use_alpha && cfg_alpha_occ > eff_cols) ||
                  (use_beta && cfg_beta_occ > eff_cols);
    acc = 0;
    if (!w.occ_error) begin
      if (use_alpha) acc = fold_products(acc, 1'b0, cfg_alpha_occ, row, col);
      if (use_beta)  acc = fold_products(acc, 1'b1, cfg_beta_occ, row, col);
    end
    w.density = acc[DENS_W-1:0];
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic signed [COEFF_IN_W-1:0] random_coeff();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return '0;
      3:       return -16'sd1;
      default: return COEFF_IN_W'($urandom);
    endcase
  endfunction

  function automatic void push_word(logic op, logic [SPIN_W-1:0] spin,
                                    logic [IDX_IN_W-1:0] row, logic [IDX_IN_W-1:0] col,
                                    logic signed [COEFF_IN_W-1:0] coeff);
    request_word_t w;
    w = '{opcode: op, spin: spin, row: row, col: col, coeff: coeff};
    pending_words.push_back(w);
    words_queued++;
    if (op == OP_WRITE && spin == SPIN_ALPHA) alpha_loaded[row][col] = 1'b1;
    if (op == OP_WRITE && spin == SPIN_BETA)  beta_loaded[row][col]  = 1'b1;
  endfunction

  // Queue a density read, preceded by writes for any coefficient it would
  // touch that has not been loaded yet.
  function automatic void push_density_read(logic [SPIN_W-1:0] spin,
                                            logic [IDX_IN_W-1:0] row,
                                            logic [IDX_IN_W-1:0] col);
    int span_a;
    int span_b;
    logic [IDX_IN_W-1:0] r;
    span_a = (spin == SPIN_BETA)  ? 0 : ((cfg_alpha_occ > BASIS) ? BASIS : cfg_alpha_occ);
    span_b = (spin == SPIN_ALPHA) ? 0 : ((cfg_beta_occ > BASIS) ? BASIS : cfg_beta_occ);
    for (int pass = 0; pass < 2; pass++) begin
      r = pass ? col : row;
      for (int k = 0; k < span_a; k++)
        if (!alpha_loaded[r][k]) push_word(OP_WRITE, SPIN_ALPHA, r, k, random_coeff());
      for (int k = 0; k < span_b; k++)
        if (!beta_loaded[r][k]) push_word(OP_WRITE, SPIN_BETA, r, k, random_coeff());
    end
    push_word(OP_READ, spin, row, col, COEFF_IN_W'($urandom));
  endfunction

  // Hold until every queued word is taken and every density word is back,
  // then let a write still in the pipe drain.
  task automatic wait_quiet();
    while (words_accepted != words_queued || density_expect_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ALPHA_OCC: cfg_alpha_occ = data[OCC_W-1:0];
      REG_BETA_OCC:  cfg_beta_occ  = data[OCC_W-1:0];
      default:       cfg_columns   = data[OCC_W-1:0];
    endcase
  endtask

  task automatic apply_config(int a_occ, int b_occ, int cols);
    wait_quiet();
    apb_write(REG_ALPHA_OCC, PDATA_W'(a_occ));
    apb_write(REG_BETA_OCC, PDATA_W'(b_occ));
    apb_write(REG_COLUMNS, PDATA_W'(cols));
  endtask

  // One configuration phase of mixed traffic. Writes to spin 2/3 are dropped
  // by the block and are not counted against the budget.
  task automatic run_phase(int a_occ, int b_occ, int cols, int budget);
    int issued_base;
    int dropped;
    int pick;
    apply_config(a_occ, b_occ, cols);
    issued_base = words_queued;
    dropped     = 0;
    while (words_queued - issued_base - dropped < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        push_density_read(SPIN_W'($urandom_range(0, 3)), IDX_IN_W'($urandom),
                          IDX_IN_W'($urandom));
      end else if (pick < 93) begin
        push_word(OP_WRITE, SPIN_W'($urandom_range(0, 1)), IDX_IN_W'($urandom),
                  IDX_IN_W'($urandom), random_coeff());
      end else begin
        push_word(OP_WRITE, SPIN_W'($urandom_range(2, 3)), IDX_IN_W'($urandom),
                  IDX_IN_W'($urandom), random_coeff());
        dropped++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed words, then random phases over the
  // register space, including zero columns and counts past the basis.
  // ---------------------------------------------------------------------------
  initial begin
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    in_bus.valid          = 1'b0;
    in_bus.opcode         = OP_WRITE;
    in_bus.spin_select    = SPIN_ALPHA;
    in_bus.row_index      = '0;
    in_bus.col_index      = '0;
    in_bus.coeff_value    = '0;
    out_bus.ready         = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset values: zero occupation, so every read is an empty sum.
    push_density_read(SPIN_ALPHA, 4'd0, 4'd0);
    push_density_read(SPIN_BETA, 4'd15, 4'd15);
    push_density_read(SPIN_TOTAL, 4'd3, 4'd12);

    // Extreme coefficients at the corner rows, then the dropped spin codes
    // aimed at loaded entries so any leak shows up in the reads after.
    apply_config(2, 2, 16);
    push_word(OP_WRITE, SPIN_ALPHA, 4'd0, 4'd0, 16'sh8000);
    push_word(OP_WRITE, SPIN_ALPHA, 4'd0, 4'd1, 16'sh8000);
    push_word(OP_WRITE, SPIN_ALPHA, 4'd15, 4'd0, 16'sh7FFF);
    push_word(OP_WRITE, SPIN_ALPHA, 4'd15, 4'd1, 16'sh7FFF);
    push_word(OP_WRITE, SPIN_BETA, 4'd0, 4'd0, 16'sh7FFF);
    push_word(OP_WRITE, SPIN_BETA, 4'd0, 4'd1, 16'sh8000);
    push_word(OP_WRITE, SPIN_BETA, 4'd15, 4'd0, 16'sh8000);
    push_word(OP_WRITE, SPIN_BETA, 4'd15, 4'd1, 16'sh7FFF);
    push_word(OP_WRITE, SPIN_TOTAL, 4'd0, 4'd0, 16'sh1234);
    push_word(OP_WRITE, SPIN_TOTAL_ALIAS, 4'd15, 4'd1, 16'sh0000);
    push_density_read(SPIN_ALPHA, 4'd0, 4'd0);
    push_density_read(SPIN_ALPHA, 4'd0, 4'd15);
    push_density_read(SPIN_BETA, 4'd15, 4'd0);
    push_density_read(SPIN_TOTAL, 4'd15, 4'd15);
    push_density_read(SPIN_TOTAL_ALIAS, 4'd0, 4'd15);

    run_phase(16, 16, 16, PHASE_WORDS);
    run_phase(0, 16, 16, PHASE_WORDS);
    run_phase(16, 0, 31, PHASE_WORDS);
    run_phase(5, 9, 12, PHASE_WORDS);
    run_phase(31, 3, 16, PHASE_WORDS);   // alpha count past the columns
    run_phase(4, 4, 0, PHASE_WORDS);     // no column in use
    run_phase(0, 0, 0, PHASE_WORDS);
    run_phase(1, 1, 1, PHASE_WORDS);
    run_phase(17, 16, 31, PHASE_WORDS);  // columns clamp to the basis
    run_phase(16, 16, 17, PHASE_WORDS);
    run_phase($urandom_range(0, 17), $urandom_range(0, 17), $urandom_range(0, 31),
              PHASE_WORDS);
    run_phase($urandom_range(0, 16), $urandom_range(0, 16), 16, PHASE_WORDS);

    wait_quiet();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: offer queued words in bursts of random length with random gaps.
  // Advance only when the current word is taken or none is offered.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk_i) begin : drive_words
    request_word_t w;
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_bus.ready) begin
      if (gap_left != 0) begin
        gap_left     <= gap_left - 1;
        in_bus.valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        w = pending_words.pop_front();
        in_bus.valid       <= 1'b1;
        in_bus.opcode      <= w.opcode;
        in_bus.spin_select <= w.spin;
        in_bus.row_index   <= w.row;
        in_bus.col_index   <= w.col;
        in_bus.coeff_value <= w.coeff;
        // Close the burst: pick the next length and a gap, none a quarter
        // of the time so long back-to-back stretches occur too.
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall on a mode that changes now and then. Every few hundred
  // reads, hold off for a long stretch so the block fills and stalls its input.
  // ---------------------------------------------------------------------------
  rx_mode_e rx_mode       = RX_OPEN;
  int       mode_left     = 0;
  logic [7:0] stall_pattern = 8'b1011_0110;
  int       holdoff_left  = 0;
  int       next_holdoff_at = 40;

  // Count the long hold-off in cycles, apart from the stall pattern.
  always @(posedge clk_i) begin : count_holdoff
    if (!rst_ni) begin
      holdoff_left <= 0;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
    end else if (reads_seen >= next_holdoff_at) begin
      holdoff_left    <= $urandom_range(200, 400);
      next_holdoff_at <= next_holdoff_at + 350;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else if (holdoff_left != 0 || reads_seen >= next_holdoff_at) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode_left     <= $urandom_range(32, 256);
        rx_mode       <= rx_mode_e'($urandom_range(0, 3));
        stall_pattern <= 8'($urandom) | 8'h01;
      end else begin
        mode_left     <= mode_left - 1;
        stall_pattern <= {stall_pattern[0], stall_pattern[7:1]};
      end
      case (rx_mode)
        RX_OPEN:    out_bus.ready <= 1'b1;
        RX_COIN:    out_bus.ready <= 1'($urandom_range(0, 1));
        RX_PATTERN: out_bus.ready <= stall_pattern[0];
        default:    out_bus.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: update the predictor on every accepted request word and check
  // every accepted density word against the oldest expectation.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, density_word_t want);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("%0t %s: want %0d err %0b, got %0d err %0b", $realtime, what,
               want.density, want.occ_error, out_bus.density_value,
               out_bus.occupation_error);
  endtask

  always @(posedge clk_i) begin : watch_words
    density_word_t want;
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready) begin
        words_accepted <= words_accepted + 1;
        if (in_bus.opcode == OP_WRITE) begin
          // Spin 2 and 3 writes are dropped.
          if (in_bus.spin_select == SPIN_ALPHA)
            alpha_c[in_bus.row_index][in_bus.col_index] = in_bus.coeff_value;
          else if (in_bus.spin_select == SPIN_BETA)
            beta_c[in_bus.row_index][in_bus.col_index] = in_bus.coeff_value;
        end else begin
          density_expect_q.push_back(density_element(in_bus.spin_select,
                                                     in_bus.row_index, in_bus.col_index));
          reads_seen <= reads_seen + 1;
        end
      end
      if (out_bus.valid && out_bus.ready) begin
        if (density_expect_q.size() == 0) begin
          want = '0;
          report_mismatch("density word with none owed", want);
        end else begin
          want = density_expect_q.pop_front();
          if (out_bus.density_value !== want.density ||
              out_bus.occupation_error !== want.occ_error)
            report_mismatch("density word mismatch", want);
        end
      end
    end
  end

  // Watchdog: a hang or a density word that never comes ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("watchdog expired, %0d density words still owed", density_expect_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule
